[rtl/ship_drrip_stream_replacement_unit_assert.svh]
// Assertion macros for the replacement unit.
`ifndef SHIP_DRRIP_STREAM_REPLACEMENT_UNIT_ASSERT_SVH
`define SHIP_DRRIP_STREAM_REPLACEMENT_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SDR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SDR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sdr_pkg.sv]
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared types and constants of the replacement unit.
// ----------------------------------------------------------------------------
`default_nettype none
package sdr_pkg;
    localparam logic [1:0] RRPV_MAX   = 2'd3;
    localparam logic       CMD_VICTIM = 1'b0;
    localparam logic       CMD_UPDATE = 1'b1;
    localparam logic [1:0] DIR_NONE   = 2'd0;
    localparam logic [1:0] DIR_UP     = 2'd1;
    localparam logic [1:0] DIR_DOWN   = 2'd2;
    localparam int         ADDR_W     = 48;
    localparam int         BLOCK_BYTES = 64;

    // Config register indexes.
    localparam logic [1:0] REG_WINDOW    = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_FAR_JUMP  = 2'd2;

    // Per-set stream detector record.
    typedef struct packed {
        logic [ADDR_W-1:0] prev_addr;
        logic [2:0]        run_count;
        logic [1:0]        run_dir;
    } stream_rec_t;

    // Stream detector outcome.
    typedef struct packed {
        stream_rec_t rec;
        logic        streaming;
    } stream_res_t;

    function automatic stream_res_t stream_step(
        input stream_rec_t       cur,
        input logic [ADDR_W-1:0] addr,
        input logic [2:0]        window,
        input logic [2:0]        threshold,
        input logic [15:0]       far_jump
    );
        stream_res_t       r;
        logic [ADDR_W-1:0] delta;
        logic [ADDR_W-1:0] mag;
        logic [ADDR_W-1:0] expect_d;
        logic [1:0]        sgn;
        logic              restart;
        delta = addr - cur.prev_addr;
        // Sign test compares the addresses unsigned: negative iff addr < last.
        mag   = (addr < cur.prev_addr) ? (cur.prev_addr - addr) : delta;
        sgn   = (addr == cur.prev_addr) ? DIR_NONE :
                ((addr < cur.prev_addr) ? DIR_DOWN : DIR_UP);
        case (cur.run_dir)
            DIR_UP:   expect_d = ADDR_W'(BLOCK_BYTES);
            DIR_DOWN: expect_d = ADDR_W'(0) - ADDR_W'(BLOCK_BYTES);
            default:  expect_d = '0;
        endcase
        // Down expectation only matches a true backward step of 64.
        restart = (cur.prev_addr == '0) || (mag > ADDR_W'(far_jump)) ||
                  (delta != expect_d) ||
                  ((cur.run_dir == DIR_DOWN) && !(addr < cur.prev_addr)) ||
                  ((cur.run_dir == DIR_UP) && (addr < cur.prev_addr));
        r.rec.prev_addr = addr;
        if (restart) begin
            r.rec.run_count = 3'd1;
            r.rec.run_dir   = sgn;
        end else begin
            r.rec.run_count = (cur.run_count < window) ? cur.run_count + 3'd1
                                                       : cur.run_count;
            r.rec.run_dir   = cur.run_dir;
        end
        r.streaming = (r.rec.run_count >= threshold);
        return r;
    endfunction
endpackage
`default_nettype wire

[rtl/sdr_set_mem.sv]
// ----------------------------------------------------------------------------
// sdr_set_mem
// Per-set line state memory: RRPV, reuse bit and signature of every way,
// plus the stream record. Synchronous read: data comes the cycle after rd_en.
// ----------------------------------------------------------------------------
`default_nettype none
module sdr_set_mem
    import sdr_pkg::*;
#(
    parameter int SET_W = 11,
    parameter int WORD_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [SET_W-1:0]  rd_addr,
    output logic      [WORD_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [SET_W-1:0]  wr_addr,
    input  wire logic [WORD_W-1:0] wr_data
);
    logic [WORD_W-1:0] mem [0:(1<<SET_W)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

[rtl/ship_drrip_stream_replacement_unit.sv]
// ----------------------------------------------------------------------------
// ship_drrip_stream_replacement_unit
// SHiP signature prediction with DRRIP dueling and per-set stream detection.
// ----------------------------------------------------------------------------
// Channel | Signals                                   | Direction
// req     | req_valid/req_ready, cmd..hit             | in
// rsp     | rsp_valid/rsp_ready, victim_way..stream   | out
// cfg     | cfg_we, cfg_index, cfg_data               | in
//
// Each request passes accept (set word and counter of the new signature
// read), read (counter of the evicted line's signature read), then
// modify/write-back with the response registered. One request in flight,
// so same-set read-after-write needs no forwarding.
// After reset a clearing pass walks max(SETS, 2^SIG_BITS) entries, one per
// cycle (2048 entries by default), with req_ready low; cfg writes are taken
// throughout.
// A waiting response holds req_ready low unless it is taken in that cycle.
// Signature counters live in a second synchronous memory (2^SIG_BITS entries),
// set to 1 by the clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module ship_drrip_stream_replacement_unit
    import sdr_pkg::*;
#(
    parameter int SETS = 2048,
    parameter int WAYS = 16,
    parameter int SIG_BITS = 6,
    parameter int LEADER_SETS = 64,
    parameter int SELECTOR_MAX = 1023
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic        cmd,
    input  wire logic [10:0] set_index,
    input  wire logic [3:0]  way,
    input  wire logic [47:0] paddr,
    input  wire logic [47:0] pc,
    input  wire logic        hit,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic [3:0]       victim_way,
    output logic [1:0]       insert_rrpv,
    output logic             stream_detected,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int SET_W  = $clog2(SETS);
    localparam int WAY_W  = $clog2(WAYS);
    localparam int SIG_N  = 1 << SIG_BITS;
    localparam int CLR_N  = (SETS > SIG_N) ? SETS : SIG_N;
    localparam int CLR_W  = $clog2(CLR_N) + 1;
    localparam int SEL_W  = $clog2(SELECTOR_MAX + 1);
    localparam int STRIDE_RAW = SETS / LEADER_SETS;
    localparam int STRIDE = (STRIDE_RAW == 0) ? 1 : STRIDE_RAW;
    localparam int LINE_W = 2 + 1 + SIG_BITS;
    localparam int WORD_W = WAYS * LINE_W + $bits(stream_rec_t);
    localparam logic [SEL_W-1:0] SEL_HALF = SEL_W'(SELECTOR_MAX / 2);
    localparam logic [SEL_W-1:0] SEL_TOP  = SEL_W'(SELECTOR_MAX);

    typedef struct packed {
        logic [1:0]          rrpv;
        logic                reused;
        logic [SIG_BITS-1:0] sig;
    } line_t;

    typedef struct packed {
        line_t [WAYS-1:0] lines;
        stream_rec_t      srec;
    } set_word_t;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_MODIFY} state_t;

    state_t              state_reg;
    logic [CLR_W-1:0]    clr_reg;
    logic                cmd_reg;
    logic [SET_W-1:0]    set_reg;
    logic [WAY_W-1:0]    way_reg;
    logic [47:0]         paddr_reg;
    logic [SIG_BITS-1:0] sig_reg;
    logic                hit_reg;
    logic [1:0]          ctr_sig_reg;
    logic [2:0]          window_reg;
    logic [2:0]          threshold_reg;
    logic [15:0]         far_jump_reg;
    logic [SEL_W-1:0]    psel_reg;
    logic [4:0]          tick_reg;
    logic [3:0]          victim_reg;
    logic [1:0]          ins_reg;
    logic                strm_reg;
    logic                rsp_valid_reg;

    logic [WORD_W-1:0]   rd_data;
    logic                wr_en;
    logic [SET_W-1:0]    wr_addr;
    set_word_t           rd_word;
    set_word_t           wr_word;

    // Signature counter memory ports.
    logic                sig_rd_en;
    logic [SIG_BITS-1:0] sig_rd_addr;
    logic [1:0]          sig_rd_data;
    logic                sig_wr_en;
    logic [SIG_BITS-1:0] sig_wr_addr;
    logic [1:0]          sig_wr_data;

    // Combinational results of the modify step.
    logic [WAY_W-1:0]    vic;
    logic [1:0]          age;
    logic                found;
    stream_res_t         sres;
    logic [1:0]          ins;
    logic                bimodal;
    logic                brrip_pick;
    logic                is_srrip;
    logic                is_brrip;
    logic [SIG_BITS-1:0] old_sig;
    logic                do_pop;
    logic                req_acc;

    assign rd_word = set_word_t'(rd_data);
    assign do_pop  = rsp_valid_reg && rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign req_acc = req_valid && req_ready;

    // Signature hash and set wrap.
    logic [SIG_BITS-1:0] sig_in;
    logic [SET_W-1:0]    set_in;
    assign sig_in = SIG_BITS'(pc ^ (pc >> 6) ^ (pc >> 12));
    assign set_in = SET_W'(32'(set_index) % SETS);

    sdr_set_mem #(.SET_W(SET_W), .WORD_W(WORD_W)) u_mem (
        .clk    (clk),
        .rd_en  (req_acc),
        .rd_addr(set_in),
        .rd_data(rd_data),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_word)
    );

    // Counter of the new signature is read at accept, the evicted one in read.
    sdr_set_mem #(.SET_W(SIG_BITS), .WORD_W(2)) u_sig_mem (
        .clk    (clk),
        .rd_en  (sig_rd_en),
        .rd_addr(sig_rd_addr),
        .rd_data(sig_rd_data),
        .wr_en  (sig_wr_en),
        .wr_addr(sig_wr_addr),
        .wr_data(sig_wr_data)
    );

    // Leader classification.
    always_comb
    begin
        is_srrip = ((32'(set_reg) / STRIDE) < LEADER_SETS) && ((32'(set_reg) % STRIDE) == 0);
        is_brrip = !is_srrip && ((32'(set_reg) / STRIDE) < LEADER_SETS) &&
                   ((32'(set_reg) % STRIDE) == 1);
    end

    always_comb
    begin
        logic [1:0] maxr;
        maxr  = '0;
        vic   = '0;
        found = 1'b0;
        for (int w = 0; w < WAYS; w++)
            if (rd_word.lines[w].rrpv > maxr)
                maxr = rd_word.lines[w].rrpv;
        // Aging amount: raise the set so its oldest line reaches 3.
        age = RRPV_MAX - maxr;
        for (int w = 0; w < WAYS; w++)
            if (!found && rd_word.lines[w].rrpv == maxr)
            begin
                vic   = WAY_W'(w);
                found = 1'b1;
            end
        sres = stream_step(rd_word.srec, paddr_reg, window_reg, threshold_reg,
                           far_jump_reg);
        brrip_pick = is_brrip || (!is_srrip && (psel_reg < SEL_HALF));
        bimodal    = 1'b0;
        if (sres.streaming || ctr_sig_reg == 2'd0)
            ins = RRPV_MAX;
        else if (brrip_pick)
        begin
            bimodal = 1'b1;
            ins = (tick_reg == 5'd0) ? RRPV_MAX - 2'd1 : RRPV_MAX;
        end
        else
            ins = RRPV_MAX - 2'd1;
        old_sig = rd_word.lines[way_reg].sig;

        wr_word = rd_word;
        if (cmd_reg == CMD_VICTIM)
        begin
            for (int w = 0; w < WAYS; w++)
                wr_word.lines[w].rrpv = rd_word.lines[w].rrpv + age;
        end
        else
        begin
            wr_word.srec = sres.rec;
            wr_word.lines[way_reg].rrpv   = hit_reg ? 2'd0 : ins;
            wr_word.lines[way_reg].reused = hit_reg;
            wr_word.lines[way_reg].sig    = sig_reg;
        end
        if (state_reg == ST_CLEAR)
        begin
            for (int w = 0; w < WAYS; w++)
                wr_word.lines[w] = '{rrpv: RRPV_MAX, reused: 1'b0, sig: '0};
            wr_word.srec = '0;
        end
        wr_en   = ((state_reg == ST_CLEAR) && (clr_reg < CLR_W'(SETS))) ||
                  (state_reg == ST_MODIFY);
        wr_addr = (state_reg == ST_CLEAR) ? clr_reg[SET_W-1:0] : set_reg;

        sig_rd_en   = req_acc || (state_reg == ST_READ);
        sig_rd_addr = (state_reg == ST_READ) ? old_sig : sig_in;
        sig_wr_en   = ((state_reg == ST_CLEAR) && (clr_reg < CLR_W'(SIG_N))) ||
                      ((state_reg == ST_MODIFY) && (cmd_reg == CMD_UPDATE));
        if (state_reg == ST_CLEAR)
        begin
            sig_wr_addr = clr_reg[SIG_BITS-1:0];
            sig_wr_data = 2'd1;
        end
        else if (hit_reg)
        begin
            // Hit trains its own signature up.
            sig_wr_addr = sig_reg;
            sig_wr_data = (ctr_sig_reg == 2'd3) ? 2'd3 : ctr_sig_reg + 2'd1;
        end
        else
        begin
            // Fill trains the evicted line's signature down if never reused.
            sig_wr_addr = old_sig;
            if (!rd_word.lines[way_reg].reused && sig_rd_data != 2'd0)
                sig_wr_data = sig_rd_data - 2'd1;
            else
                sig_wr_data = sig_rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            window_reg    <= 3'd4;
            threshold_reg <= 3'd3;
            far_jump_reg  <= 16'd1024;
            psel_reg      <= SEL_HALF;
            tick_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            victim_reg    <= '0;
            ins_reg       <= '0;
            strm_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW:    window_reg    <= cfg_data[2:0];
                    REG_THRESHOLD: threshold_reg <= cfg_data[2:0];
                    REG_FAR_JUMP:  far_jump_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_MODIFY)
                rsp_valid_reg <= 1'b1;
            else if (do_pop)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLR_W'(CLR_N - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                    if (req_acc)
                        state_reg <= ST_READ;
                ST_READ:
                    state_reg <= ST_MODIFY;
                ST_MODIFY:
                begin
                    state_reg  <= ST_IDLE;
                    victim_reg <= (cmd_reg == CMD_VICTIM) ? 4'(vic) : 4'd0;
                    ins_reg    <= (cmd_reg == CMD_UPDATE && !hit_reg) ? ins : 2'd0;
                    strm_reg   <= (cmd_reg == CMD_UPDATE) ? sres.streaming : 1'b0;
                    if (cmd_reg == CMD_UPDATE && !hit_reg)
                    begin
                        if (bimodal)
                            tick_reg <= tick_reg + 5'd1;
                        if (is_srrip && psel_reg != '0)
                            psel_reg <= psel_reg - 1'b1;
                        else if (is_brrip && psel_reg != SEL_TOP)
                            psel_reg <= psel_reg + 1'b1;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Request payload capture.
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            cmd_reg   <= cmd;
            set_reg   <= set_in;
            way_reg   <= WAY_W'(32'(way) % WAYS);
            paddr_reg <= paddr;
            sig_reg   <= sig_in;
            hit_reg   <= hit;
        end
        if (state_reg == ST_READ)
            ctr_sig_reg <= sig_rd_data;
    end

    assign rsp_valid       = rsp_valid_reg;
    assign victim_way      = victim_reg;
    assign insert_rrpv     = ins_reg;
    assign stream_detected = strm_reg;

`include "ship_drrip_stream_replacement_unit_assert.svh"

    `SDR_ASSERT_IMP(a_no_accept_busy, (state_reg != ST_IDLE), !req_ready, "accept while busy")
    `SDR_ASSERT_NXT(a_read_follows, (req_valid && req_ready), (state_reg == ST_READ), "no read")
    `SDR_ASSERT_NXT(a_rsp_after_mod, (state_reg == ST_MODIFY), rsp_valid, "no response")
endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives cache victim queries and access updates into the replacement unit,
// predicts each response from a local model of its RRPV, signature, stream
// and dueling state, and compares every response field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import sdr_pkg::*;

    localparam int NSETS      = 2048;
    localparam int NWAYS      = 16;
    localparam int NSIGS      = 64;
    localparam int SEL_TOP    = 1023;
    localparam int STRIDE     = 32;       // NSETS / leader sets
    localparam int CYC_LIMIT  = 600000;

    // dueling roles of a set
    typedef enum int {FOLLOWER, SRRIP_LEAD, BRRIP_LEAD} duel_role_t;

    typedef struct {
        logic [3:0] victim;
        logic [1:0] ins;
        logic       strm;
    } rsp_fields_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic        cmd;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic [47:0] paddr;
    logic [47:0] pc;
    logic        hit;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [3:0]  victim_way;
    logic [1:0]  insert_rrpv;
    logic        stream_detected;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    ship_drrip_stream_replacement_unit dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready),
        .cmd(cmd), .set_index(set_index), .way(way),
        .paddr(paddr), .pc(pc), .hit(hit),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
        .victim_way(victim_way), .insert_rrpv(insert_rrpv),
        .stream_detected(stream_detected),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ---------------- shadow state of the replacement policy ----------------
    logic [1:0]  rrpv_sh   [NSETS][NWAYS];
    logic        reuse_sh  [NSETS][NWAYS];
    logic [5:0]  lsig_sh   [NSETS][NWAYS];
    logic [1:0]  sig_ctr   [NSIGS];
    logic [47:0] prev_addr_sh [NSETS];
    logic [2:0]  run_cnt   [NSETS];
    logic [1:0]  run_dir   [NSETS];
    int          duel_sel;
    logic [4:0]  brrip_tick;
    logic [2:0]  win_reg;
    logic [2:0]  thr_reg;
    logic [15:0] far_reg;

    rsp_fields_t pending_rsp[$];
    int          err_count;
    int          n_victim, n_fill, n_hit, n_stream, n_checked;
    logic [3:0]  last_victim;     // predicted victim of the latest query
    bit          quiet;           // no idling on either side
    int          hold_left;       // long receiver hold-off, in cycles
    int          idle_left;       // rest of a short receiver stall burst
    int          cyc;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch #%0d at cycle %0d: %s got %0d expected %0d",
                 err_count + 1, cyc, what, got, want);
        err_count++;
    endtask

    function automatic duel_role_t role_of(input int s);
        if (s % STRIDE == 0) return SRRIP_LEAD;
        if (s % STRIDE == 1) return BRRIP_LEAD;
        return FOLLOWER;
    endfunction

    // Stride stream detector; returns the streaming flag.
    function automatic logic run_track(input int s, input logic [47:0] a);
        logic [63:0] d;
        logic [63:0] mag;
        logic [63:0] step;
        logic [1:0]  sgn;
        d    = {16'h0, a} - {16'h0, prev_addr_sh[s]};
        mag  = d[63] ? (64'h0 - d) : d;
        sgn  = (d == 64'h0) ? DIR_NONE : (d[63] ? DIR_DOWN : DIR_UP);
        step = (run_dir[s] == DIR_UP)   ? 64'd64 :
               (run_dir[s] == DIR_DOWN) ? (64'h0 - 64'd64) : 64'h0;
        if (prev_addr_sh[s] == 48'h0 || mag > {48'h0, far_reg} || d != step)
        begin
            run_cnt[s] = 3'd1;
            run_dir[s] = sgn;
        end
        else if (run_cnt[s] < win_reg)
        begin
            run_cnt[s] = run_cnt[s] + 3'd1;
        end
        prev_addr_sh[s] = a;
        return run_cnt[s] >= thr_reg;
    endfunction

    // Expected response of one accepted request; updates the shadow state.
    function automatic rsp_fields_t predict_access(input logic c, input logic [10:0] s_in,
                                                   input logic [3:0] w, input logic [47:0] a,
                                                   input logic [47:0] p, input logic h);
        rsp_fields_t r;
        int          s;
        logic [5:0]  sg;
        logic [5:0]  old_sg;
        logic [1:0]  ins;
        duel_role_t  role;
        logic        bimodal;
        bit          found;
        s = s_in;
        r.victim = '0;
        r.ins    = '0;
        r.strm   = 1'b0;
        if (c == CMD_VICTIM)
        begin
            found = 0;
            for (int rd = 0; rd < 4 && !found; rd++)
            begin
                for (int i = 0; i < NWAYS && !found; i++)
                begin
                    if (rrpv_sh[s][i] == RRPV_MAX)
                    begin
                        found = 1;
                        r.victim = 4'(i);
                    end
                end
                if (!found)
                    for (int i = 0; i < NWAYS; i++)
                        if (rrpv_sh[s][i] != RRPV_MAX) rrpv_sh[s][i]++;
            end
            return r;
        end
        r.strm = run_track(s, a);
        sg = p[5:0] ^ p[11:6] ^ p[17:12];
        if (h)
        begin
            rrpv_sh[s][w]  = 2'd0;
            reuse_sh[s][w] = 1'b1;
            lsig_sh[s][w]  = sg;
            if (sig_ctr[sg] != 2'd3) sig_ctr[sg]++;
            return r;
        end
        role = role_of(s);
        if (r.strm || sig_ctr[sg] == 2'd0)
        begin
            ins = RRPV_MAX;
        end
        else
        begin
            bimodal = (role == BRRIP_LEAD) ||
                      (role == FOLLOWER && duel_sel < SEL_TOP / 2);
            if (bimodal)
            begin
                ins = (brrip_tick == 5'd0) ? RRPV_MAX - 2'd1 : RRPV_MAX;
                brrip_tick++;
            end
            else
            begin
                ins = RRPV_MAX - 2'd1;
            end
        end
        // train the evicted line's signature before overwriting it
        old_sg = lsig_sh[s][w];
        if (!reuse_sh[s][w] && sig_ctr[old_sg] != 2'd0) sig_ctr[old_sg]--;
        rrpv_sh[s][w]  = ins;
        reuse_sh[s][w] = 1'b0;
        lsig_sh[s][w]  = sg;
        if (role == SRRIP_LEAD && duel_sel > 0) duel_sel--;
        if (role == BRRIP_LEAD && duel_sel < SEL_TOP) duel_sel++;
        r.ins = ins;
        return r;
    endfunction

    // ---------------- request side ----------------
    // Offers one request from the falling edge on; valid stays high into the
    // next request unless an idle burst follows.
    task automatic send_req(input logic c, input logic [10:0] s, input logic [3:0] w,
                            input logic [47:0] a, input logic [47:0] p, input logic h);
        rsp_fields_t e;
        @(negedge clk);
        req_valid = 1'b1;
        cmd       = c;
        set_index = s;
        way       = w;
        paddr     = a;
        pc        = p;
        hit       = h;
        do @(posedge clk); while (!req_ready);
        e = predict_access(c, s, w, a, p, h);
        pending_rsp.push_back(e);
        if (c == CMD_VICTIM) begin last_victim = e.victim; n_victim++; end
        else if (h) n_hit++;
        else n_fill++;
        if (c == CMD_UPDATE && e.strm) n_stream++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            req_valid = 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(negedge clk);
        end
    endtask

    task automatic victim_query(input logic [10:0] s);
        send_req(CMD_VICTIM, s, 4'($urandom), 48'({$urandom, $urandom}),
                 48'({$urandom, $urandom}), 1'($urandom));
    endtask

    // Waits until every response is in, then lets the pipeline settle.
    task automatic drain;
        @(negedge clk);
        req_valid = 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_WINDOW:    win_reg = val[2:0];
            REG_THRESHOLD: thr_reg = val[2:0];
            REG_FAR_JUMP:  far_reg = val;
            default: ;
        endcase
    endtask

    // ---------------- response side ----------------
    // Random stall bursts, plus the long hold-off used for back-pressure.
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else if (idle_left > 0)
        begin
            idle_left <= idle_left - 1;
            rsp_ready <= 1'b0;
        end
        else if (!quiet && rsp_ready && $urandom_range(0, 5) == 0)
        begin
            idle_left <= $urandom_range(1, 14) - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Compare every accepted response with the oldest prediction.
    always @(posedge clk)
    begin
        rsp_fields_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
                report("response with none pending", 0, 0);
            else
            begin
                e = pending_rsp.pop_front();
                n_checked++;
                if (victim_way !== e.victim)
                    report("victim_way", int'(victim_way), int'(e.victim));
                if (insert_rrpv !== e.ins)
                    report("insert_rrpv", int'(insert_rrpv), int'(e.ins));
                if (stream_detected !== e.strm)
                    report("stream_detected", int'(stream_detected), int'(e.strm));
            end
        end
    end

    // Watchdog; the clearing pass after reset is well inside the margin.
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses pending", cyc,
                     pending_rsp.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- tests ----------------
    // Extremes of the fields, victim aging on a full set, hits and fills.
    task automatic test_directed_basics;
        victim_query(11'd0);                 // fresh set: way 0
        victim_query(11'd2047);
        for (int i = 0; i < 4; i++)
        begin
            victim_query(11'd7);
            send_req(CMD_UPDATE, 11'd7, last_victim, 48'h1000 * (i + 1), 48'h400, 1'b0);
        end
        send_req(CMD_UPDATE, 11'd7, 4'd15, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_req(CMD_UPDATE, 11'd7, 4'd0, 48'h0, 48'h0, 1'b1);
        // fill all ways of one set so that the query must age the set
        for (int i = 0; i < NWAYS; i++)
            send_req(CMD_UPDATE, 11'd9, 4'(i), 48'h8_0000 + 48'h4000 * i, 48'h123, 1'b1);
        victim_query(11'd9);
        victim_query(11'd9);
    endtask

    // Drain a signature counter to zero through unreused fills.
    task automatic test_dead_signature;
        for (int i = 0; i < 4; i++)
            send_req(CMD_UPDATE, 11'd5, 4'd3, 48'h10_0000 * (i + 1), 48'h0, 1'b0);
    endtask

    // Leader sets move the selector; followers follow it.
    task automatic test_dueling;
        for (int i = 0; i < 6; i++)
        begin
            send_req(CMD_UPDATE, 11'd33, 4'(i), 48'h20_0000 * (i + 1), 48'h77, 1'b0);
            send_req(CMD_UPDATE, 11'd64, 4'(i), 48'h20_0000 * (i + 1), 48'h77, 1'b0);
            send_req(CMD_UPDATE, 11'd100, 4'(i), 48'h20_0000 * (i + 1), 48'h77, 1'b0);
        end
    endtask

    // Up and down strides, a far jump and a broken run under one setting.
    task automatic stream_runs(input int s, input int len);
        logic [47:0] a;
        a = 48'h40_0000 + 48'($urandom_range(1, 1000) << 6);
        for (int i = 0; i < len; i++)
            send_req(CMD_UPDATE, 11'(s), 4'($urandom), a + 48'(64 * i), 48'h55, 1'b0);
        for (int i = 0; i < len; i++)
            send_req(CMD_UPDATE, 11'(s), 4'($urandom), a - 48'(64 * i), 48'h56,
                     1'($urandom));
        send_req(CMD_UPDATE, 11'(s), 4'd1, a + 48'h1_0000, 48'h57, 1'b0);
        send_req(CMD_UPDATE, 11'(s), 4'd2, a + 48'h1_0000 + 128, 48'h57, 1'b0);
    endtask

    task automatic test_config_sweep;
        int w[5] = '{0, 7, 7, 1, 4};
        int t[5] = '{0, 7, 1, 7, 3};
        int f[5] = '{64, 65535, 64, 0, 1024};
        for (int k = 0; k < 5; k++)
        begin
            cfg_write(REG_WINDOW, 16'(w[k]));
            cfg_write(REG_THRESHOLD, 16'(t[k]));
            cfg_write(REG_FAR_JUMP, 16'(f[k]));
            stream_runs(200 + k, 9);
        end
    endtask

    // Receiver holds off while requests keep coming, so the unit backs up.
    task automatic test_backpressure;
        drain();
        hold_left = 300;
        for (int i = 0; i < 20; i++)
            send_req(1'($urandom), 11'($urandom_range(0, 40)), 4'($urandom),
                     48'($urandom_range(1, 9) << 6), 48'($urandom), 1'($urandom));
    endtask

    // Mostly well-formed traffic: strided runs of query then fill, reuse hits,
    // and some fully random noise.
    task automatic test_random_traffic(input int count);
        int          sent;
        int          s;
        int          len;
        int          dir;
        logic [47:0] a;
        logic [47:0] p;
        sent = 0;
        while (sent < count)
        begin
            if (sent > count - 200) quiet = 1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    s   = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047)
                                                    : $urandom_range(0, 70);
                    len = $urandom_range(2, 8);
                    dir = $urandom_range(0, 1) ? 64 : -64;
                    a   = 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_FFC0;
                    p   = $urandom_range(0, 1) ? 48'($urandom_range(0, 15) << 12)
                                               : 48'({$urandom, $urandom});
                    for (int i = 0; i < len; i++)
                    begin
                        victim_query(11'(s));
                        send_req(CMD_UPDATE, 11'(s), last_victim, a + 48'(dir * i), p,
                                 $urandom_range(0, 4) == 0);
                        sent += 2;
                    end
                end
                6, 7, 8:
                begin
                    s = $urandom_range(0, 70);
                    send_req(CMD_UPDATE, 11'(s), 4'($urandom),
                             48'($urandom_range(1, 4096) << 6),
                             48'($urandom_range(0, 15) << 12), 1'b1);
                    sent++;
                end
                default:
                begin
                    send_req(1'($urandom), 11'($urandom), 4'($urandom),
                             48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                             1'($urandom));
                    sent++;
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0; cmd = 1'b0; set_index = '0; way = '0;
        paddr = '0; pc = '0; hit = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        rsp_ready = 1'b0;
        cyc = 0; hold_left = 0; idle_left = 0; quiet = 0; err_count = 0;
        n_victim = 0; n_fill = 0; n_hit = 0; n_stream = 0; n_checked = 0;
        last_victim = '0;
        for (int s = 0; s < NSETS; s++)
        begin
            for (int i = 0; i < NWAYS; i++)
            begin
                rrpv_sh[s][i] = RRPV_MAX; reuse_sh[s][i] = 1'b0; lsig_sh[s][i] = '0;
            end
            prev_addr_sh[s] = '0; run_cnt[s] = '0; run_dir[s] = DIR_NONE;
        end
        for (int i = 0; i < NSIGS; i++) sig_ctr[i] = 2'd1;
        duel_sel = SEL_TOP / 2; brrip_tick = '0;
        win_reg = 3'd4; thr_reg = 3'd3; far_reg = 16'd1024;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_basics();
        test_dead_signature();
        test_dueling();
        test_config_sweep();
        test_backpressure();
        test_random_traffic(830);
        drain();
        repeat (10) @(posedge clk);

        $display("covered %0d victim queries, %0d fills, %0d hits, %0d streaming updates",
                 n_victim, n_fill, n_hit, n_stream);
        $display("%0d responses checked across five detector settings, selector at %0d",
                 n_checked, duel_sel);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/sdr_pkg.sv
rtl/sdr_set_mem.sv
rtl/ship_drrip_stream_replacement_unit.sv
tb/tb_top.sv
